// ----- rtl/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame statistics package
// Shared types, constants and a helper function of the frame min/max/mean block.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int unsigned PIXEL_W     = 8;
   localparam int unsigned CFG_W       = 13;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned SUM_W       = 32;
   localparam int unsigned NUM_W       = SUM_W + 1;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } imm_state_type;

   typedef struct packed {
      logic accept;
      logic frame_end;
      logic load_out;
   } imm_cmd_type;

   typedef struct packed {
      logic frame_last;
      logic dims_ok;
      logic div_busy;
      logic out_free;
   } imm_status_type;

   function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] value,
                                             input logic [31:0] limit);
      logic [31:0] v;
      v = 32'(value);
      if (v == 32'd0) begin
         return 32'd1;
      end else if (v > limit) begin
         return limit;
      end
      return v;
   endfunction

endpackage

// ----- rtl/imm_div.sv -----
// ----------------------------------------------------------------------------
// Frame statistics divider
// Restoring divider that resolves one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module imm_div #(
   parameter int unsigned DIV_W = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [imm_pkg::NUM_W-1:0]      dividend,
   input  logic [DIV_W-1:0]               divisor,
   output logic                           busy,
   output logic [imm_pkg::PIXEL_W-1:0]    quotient
);

   localparam int unsigned CW = $clog2(imm_pkg::NUM_W + 1);

   logic [imm_pkg::NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          den_ff, den_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [DIV_W:0]            shifted;
   logic [DIV_W:0]            diff;
   logic                      fits;

   assign shifted = {rem_ff, num_ff[imm_pkg::NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CW'(imm_pkg::NUM_W);
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[imm_pkg::NUM_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = num_ff[imm_pkg::PIXEL_W-1:0];

endmodule

// ----- rtl/imm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame statistics controller
// Sequences pixel acceptance, the end-of-frame divide and the result hand-off.
// ----------------------------------------------------------------------------
module imm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  imm_pkg::imm_status_type status,
   output imm_pkg::imm_cmd_type    cmd
);

   imm_pkg::imm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.frame_end = 1'b0;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            req_ready     = status.dims_ok;
            cmd.accept    = req_valid && req_ready;
            cmd.frame_end = cmd.accept && status.frame_last;
            if (cmd.frame_end) begin
               state_in = imm_pkg::ST_DIVIDE;
            end
         end
         imm_pkg::ST_DIVIDE: begin
            req_ready  = status.dims_ok && !status.frame_last;
            cmd.accept = req_valid && req_ready;
            if (!status.div_busy && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = imm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/imm_datapath.sv -----
// ----------------------------------------------------------------------------
// Frame statistics datapath
// Frame size registers, running accumulators, divider and result register.
// ----------------------------------------------------------------------------
module imm_datapath #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  imm_pkg::imm_cmd_type             cmd,
   output imm_pkg::imm_status_type          status,
   input  logic [imm_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             csr_write,
   input  logic [imm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [imm_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_minimum,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_maximum,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_average
);

   localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW      = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned MAX_PIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned CNT_W   = $clog2(MAX_PIX + 1);

   logic [WW-1:0]                 wd_ff, wd_in;
   logic [HW-1:0]                 ht_ff, ht_in;
   logic [WW+HW-1:0]              product;
   logic [CNT_W-1:0]              n_ff;
   logic                          dims_ok_ff;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W:0]                cnt_inc;
   logic [imm_pkg::PIXEL_W-1:0]   min_ff, min_in, min_next;
   logic [imm_pkg::PIXEL_W-1:0]   max_ff, max_in, max_next;
   logic [imm_pkg::SUM_W-1:0]     sum_ff, sum_in, sum_next;
   logic [imm_pkg::PIXEL_W-1:0]   snap_min_ff, snap_max_ff;
   logic [imm_pkg::NUM_W-1:0]     dividend;
   logic                          div_busy;
   logic [imm_pkg::PIXEL_W-1:0]   quotient;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::PIXEL_W-1:0]   rsp_min_ff, rsp_max_ff, rsp_avg_ff;

   // Frame size registers hold the already clamped dimensions.
   always_comb begin
      wd_in = wd_ff;
      ht_in = ht_ff;
      if (csr_write) begin
         unique case (csr_index)
            imm_pkg::CSR_FRAME_WIDTH:  wd_in = WW'(imm_pkg::clamp_dim(csr_wdata, MAX_WIDTH));
            imm_pkg::CSR_FRAME_HEIGHT: ht_in = HW'(imm_pkg::clamp_dim(csr_wdata, MAX_HEIGHT));
            default: ;
         endcase
      end
   end

   assign product = (WW+HW)'(wd_ff) * (WW+HW)'(ht_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_ff      <= WW'(imm_pkg::clamp_dim(imm_pkg::RESET_FRAME_WIDTH, MAX_WIDTH));
         ht_ff      <= HW'(imm_pkg::clamp_dim(imm_pkg::RESET_FRAME_HEIGHT, MAX_HEIGHT));
         dims_ok_ff <= 1'b0;
      end else begin
         wd_ff      <= wd_in;
         ht_ff      <= ht_in;
         dims_ok_ff <= !csr_write;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= CNT_W'(product);
   end

   // Running accumulators.
   assign cnt_inc  = {1'b0, cnt_ff} + 1'b1;
   assign min_next = (req_pixel < min_ff) ? req_pixel : min_ff;
   assign max_next = (req_pixel > max_ff) ? req_pixel : max_ff;
   assign sum_next = sum_ff + imm_pkg::SUM_W'(req_pixel);

   always_comb begin
      cnt_in = cnt_ff;
      min_in = min_ff;
      max_in = max_ff;
      sum_in = sum_ff;
      if (cmd.frame_end) begin
         cnt_in = '0;
         min_in = imm_pkg::PIXEL_MAX;
         max_in = '0;
         sum_in = '0;
      end else if (cmd.accept) begin
         cnt_in = cnt_inc[CNT_W-1:0];
         min_in = min_next;
         max_in = max_next;
         sum_in = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         min_ff <= imm_pkg::PIXEL_MAX;
         max_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         min_ff <= min_in;
         max_ff <= max_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_end) begin
         snap_min_ff <= min_next;
         snap_max_ff <= max_next;
      end
   end

   assign dividend = {1'b0, sum_next} + imm_pkg::NUM_W'(n_ff >> 1);

   imm_div #(
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.frame_end),
      .dividend (dividend),
      .divisor  (n_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_min_ff <= snap_min_ff;
         rsp_max_ff <= snap_max_ff;
         rsp_avg_ff <= quotient;
      end
   end

   assign status.frame_last = cnt_inc >= {1'b0, n_ff};
   assign status.dims_ok    = dims_ok_ff;
   assign status.div_busy   = div_busy;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_minimum = rsp_min_ff;
   assign rsp_maximum = rsp_max_ff;
   assign rsp_average = rsp_avg_ff;

endmodule

// ----- rtl/image_min_max_mean.sv -----
// ----------------------------------------------------------------------------
// Frame minimum, maximum and mean
// Collects the statistics of one frame of 8-bit pixels and reports them.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the req_ channel, one per transaction, and
// are taken at one per clock cycle except where intake pauses as set out
// below. The frame size comes from two registers written on the csr_ channel
// (index 0 width, index 1 height); a zero size is taken as one and an
// oversized one as the maximum. Writes are always taken, and pixel intake
// pauses after each write while the frame size product is recomputed. The
// transaction that completes a frame starts a restoring divide, one quotient
// bit per cycle; once the divide is done and the output register is free, one
// result transaction with minimum, maximum and rounded mean appears on the
// rsp_ channel. Pixels of the next frame keep flowing during the divide; only
// the pixel that would complete another frame waits until the previous result
// has moved into the output register. A stalled result holds in the output
// register and the divider result waits behind it. Reset restores a 640 by
// 480 frame and clears all running statistics.
// ----------------------------------------------------------------------------
module image_min_max_mean #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [imm_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_minimum,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_maximum,
   output logic [imm_pkg::PIXEL_W-1:0]      rsp_average,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [imm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [imm_pkg::CFG_W-1:0]        csr_wdata
);

   imm_pkg::imm_cmd_type    cmd;
   imm_pkg::imm_status_type status;

   assign csr_ready = 1'b1;

   imm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   imm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_pixel   (req_pixel),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_minimum (rsp_minimum),
      .rsp_maximum (rsp_maximum),
      .rsp_average (rsp_average)
   );

endmodule
